FILE: design/ipv4_cidr_list_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IPv4 CIDR list parser.
// Each macro places one labeled concurrent assertion on the rising clock
// edge, disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef IPV4_CIDR_LIST_PARSER_TOP_ASSERT_SVH
`define IPV4_CIDR_LIST_PARSER_TOP_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ICP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Consequent in the cycle after the antecedent.
`define ICP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

FILE: design/icp_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 CIDR list parser package
// Status and request codes, character codes, limits, queue geometry, the token phase type and the result record.
// ----------------------------------------------------------------------------
package icp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TOKEN = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ST_ACCEPTED  = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  // Request types.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Limits on octet and prefix values.
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [9:0]  PREFIX_MAX = 10'd32;
  localparam logic [5:0]  PREFIX_DEF = 6'd32;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  // Position inside a token.
  typedef enum logic [2:0] {
    PH_ADDR   = 3'b001,
    PH_PREFIX = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  // One result record.
  typedef struct packed {
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [2:0]  status;
    logic        last;
  } result_t;

endpackage

FILE: design/ipv4_cidr_list_parser_top.sv
// ----------------------------------------------------------------------------
// IPv4 CIDR list parser
// Parses a byte stream of dotted IPv4 addresses with optional /prefix.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_req_type, in_char_byte) carries
//   one character per transfer, or an end-of-list marker (req_type = 1).
//   The result channel (out_valid, out_stall, out_address, out_prefix_len,
//   out_status, out_last) carries parsed addresses and error or list status.
//   Each input causes zero, one or two results; out_last marks the final one.
//   The input transfer loads the input register; the parse step then
//   writes the results into a four-entry result queue, and out_valid is
//   high while the queue holds a result.
//   Throughput: one input per cycle; the input stalls only when the
//   result queue holds more than two entries, so the drain rate of the
//   result side sets the sustained rate.
//   Reset (rst_n low at a clock edge) empties the input register and the
//   queue and clears the token and list state.
//   When the receiver stalls, the head result holds and the queue fills;
//   the input side then stalls in turn.
// ----------------------------------------------------------------------------
`include "ipv4_cidr_list_parser_top_assert.svh"

module ipv4_cidr_list_parser_top #(
  parameter int MAX_TOKEN_LEN = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_address,
  output logic [5:0]  out_prefix_len,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int TLW = $clog2(MAX_TOKEN_LEN + 1);

  // Input register.
  logic       stg_valid_r, stg_valid_nxt;
  logic       stg_req_r;
  logic [7:0] stg_char_r;

  // Token and list state.
  logic [7:0]      oct_r [4];
  logic [7:0]      oct_nxt [4];
  logic [1:0]      part_r, part_nxt;
  logic [1:0]      dcnt_r, dcnt_nxt;
  icp_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      pfx_r, pfx_nxt;
  logic [TLW-1:0]  tlen_r, tlen_nxt;
  logic            bad_r, bad_nxt;
  logic            lfail_r, lfail_nxt;

  // Result queue.
  icp_pkg::result_t              q_r [icp_pkg::QDEPTH];
  logic [icp_pkg::QPW-1:0]       wr_r, rd_r;
  logic [icp_pkg::QCW-1:0]       cnt_r;
  logic                          pop;
  logic                          proc;
  logic [1:0]                    push_n;
  icp_pkg::result_t              res0, res1, fin_res;

  // Character decode and token evaluation.
  logic        is_digit, is_delim, is_tokch;
  logic [3:0]  dval;
  logic [11:0] oct_ext, oct_v;
  logic [9:0]  pfx_ext, pfx_v;
  logic        pending, good;

  assign proc     = stg_valid_r && (cnt_r <= icp_pkg::QCW'(2));
  assign in_stall = stg_valid_r && !proc;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;

  assign out_address    = q_r[rd_r].address;
  assign out_prefix_len = q_r[rd_r].prefix_len;
  assign out_status     = q_r[rd_r].status;
  assign out_last       = q_r[rd_r].last;

  // Character classes and digit arithmetic.
  assign is_digit = (stg_char_r >= icp_pkg::CH_ZERO) && (stg_char_r <= icp_pkg::CH_NINE);
  assign is_tokch = is_digit || (stg_char_r == icp_pkg::CH_DOT) ||
                    (stg_char_r == icp_pkg::CH_SLASH);
  assign is_delim = (stg_char_r == icp_pkg::CH_SPACE) || (stg_char_r == icp_pkg::CH_NL) ||
                    (stg_char_r == icp_pkg::CH_COMMA);
  assign dval     = stg_char_r[3:0];
  assign oct_ext  = {4'b0, oct_r[part_r]};
  assign oct_v    = (oct_ext << 3) + (oct_ext << 1) + {8'b0, dval};
  assign pfx_ext  = {4'b0, pfx_r};
  assign pfx_v    = (pfx_ext << 3) + (pfx_ext << 1) + {6'b0, dval};

  // Evaluation of the pending token at a delimiter or end marker.
  always_comb begin
    pending = (tlen_r != '0);
    case (phase_r)
      icp_pkg::PH_ADDR:   good = !bad_r && (dcnt_r != 2'd0) && (part_r == 2'd3);
      icp_pkg::PH_PREFIX: good = !bad_r && (dcnt_r != 2'd0);
      default:            good = !bad_r;
    endcase
    if (good) begin
      fin_res.address    = {oct_r[0], oct_r[1], oct_r[2], oct_r[3]};
      fin_res.prefix_len = (phase_r == icp_pkg::PH_ADDR) ? icp_pkg::PREFIX_DEF : pfx_r;
      fin_res.status     = icp_pkg::ST_OK;
    end else begin
      fin_res.address    = '0;
      fin_res.prefix_len = '0;
      fin_res.status     = icp_pkg::ST_BAD_TOKEN;
    end
    fin_res.last = 1'b1;
  end

  // Parse step for the item in the input register.
  always_comb begin
    oct_nxt   = oct_r;
    part_nxt  = part_r;
    dcnt_nxt  = dcnt_r;
    phase_nxt = phase_r;
    pfx_nxt   = pfx_r;
    tlen_nxt  = tlen_r;
    bad_nxt   = bad_r;
    lfail_nxt = lfail_r;
    push_n    = 2'd0;
    res0      = '{address: '0, prefix_len: '0, status: icp_pkg::ST_OK, last: 1'b1};
    res1      = res0;

    if (proc) begin
      if (stg_req_r == icp_pkg::REQ_END) begin
        // End of list: flush any pending token, then report the list.
        res1.status = (lfail_r || (pending && !good)) ? icp_pkg::ST_REJECTED
                                                      : icp_pkg::ST_ACCEPTED;
        if (!lfail_r && pending) begin
          res0      = fin_res;
          res0.last = 1'b0;
          push_n    = 2'd2;
        end else begin
          res0   = res1;
          push_n = 2'd1;
        end
        lfail_nxt = 1'b0;
        tlen_nxt  = '0;
        bad_nxt   = 1'b0;
        part_nxt  = 2'd0;
        dcnt_nxt  = 2'd0;
        phase_nxt = icp_pkg::PH_ADDR;
        pfx_nxt   = '0;
        for (int i = 0; i < 4; i++) oct_nxt[i] = '0;
      end else if (lfail_r) begin
        // Failed list: everything up to the end marker is dropped.
      end else if (is_tokch && (tlen_r >= TLW'(MAX_TOKEN_LEN))) begin
        // Token too long.
        res0.status = icp_pkg::ST_BAD_TOKEN;
        push_n      = 2'd1;
        lfail_nxt   = 1'b1;
      end else if (is_tokch) begin
        tlen_nxt = tlen_r + TLW'(1);
        if (!bad_r) begin
          case (phase_r)
            icp_pkg::PH_ADDR: begin
              if (is_digit) begin
                if ((dcnt_r == 2'd3) || (oct_v > icp_pkg::OCTET_MAX)) begin
                  bad_nxt = 1'b1;
                end else begin
                  oct_nxt[part_r] = oct_v[7:0];
                  dcnt_nxt        = dcnt_r + 2'd1;
                end
              end else if (stg_char_r == icp_pkg::CH_DOT) begin
                if ((dcnt_r == 2'd0) || (part_r == 2'd3)) begin
                  bad_nxt = 1'b1;
                end else begin
                  dcnt_nxt = 2'd0;
                  part_nxt = part_r + 2'd1;
                end
              end else begin
                if ((dcnt_r == 2'd0) || (part_r != 2'd3)) begin
                  bad_nxt = 1'b1;
                end else begin
                  phase_nxt = icp_pkg::PH_PREFIX;
                  dcnt_nxt  = 2'd0;
                  pfx_nxt   = '0;
                end
              end
            end
            icp_pkg::PH_PREFIX: begin
              if (is_digit) begin
                if ((dcnt_r >= 2'd2) || (pfx_v > icp_pkg::PREFIX_MAX)) begin
                  bad_nxt = 1'b1;
                end else begin
                  pfx_nxt  = pfx_v[5:0];
                  dcnt_nxt = dcnt_r + 2'd1;
                end
              end else if (dcnt_r == 2'd0) begin
                bad_nxt = 1'b1;
              end else begin
                phase_nxt = icp_pkg::PH_SKIP;
              end
            end
            default: begin
              // Rest of the token is ignored.
            end
          endcase
        end
      end else if (is_delim) begin
        // Delimiter: report the pending token, if any.
        if (pending) begin
          res0   = fin_res;
          push_n = 2'd1;
          if (!good) lfail_nxt = 1'b1;
        end
      end else begin
        // Invalid character.
        res0.status = icp_pkg::ST_BAD_CHAR;
        push_n      = 2'd1;
        lfail_nxt   = 1'b1;
      end

      // A token ends at any result from a character transfer.
      if ((stg_req_r == icp_pkg::REQ_CHAR) && (push_n != 2'd0)) begin
        tlen_nxt  = '0;
        bad_nxt   = 1'b0;
        part_nxt  = 2'd0;
        dcnt_nxt  = 2'd0;
        phase_nxt = icp_pkg::PH_ADDR;
        pfx_nxt   = '0;
        for (int i = 0; i < 4; i++) oct_nxt[i] = '0;
      end
    end
  end

  // Input register load.
  always_comb begin
    if (in_valid && !in_stall) begin
      stg_valid_nxt = 1'b1;
    end else if (proc) begin
      stg_valid_nxt = 1'b0;
    end else begin
      stg_valid_nxt = stg_valid_r;
    end
  end

  // Control and parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      part_r      <= 2'd0;
      dcnt_r      <= 2'd0;
      phase_r     <= icp_pkg::PH_ADDR;
      pfx_r       <= '0;
      tlen_r      <= '0;
      bad_r       <= 1'b0;
      lfail_r     <= 1'b0;
      for (int i = 0; i < 4; i++) oct_r[i] <= '0;
      wr_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      part_r      <= part_nxt;
      dcnt_r      <= dcnt_nxt;
      phase_r     <= phase_nxt;
      pfx_r       <= pfx_nxt;
      tlen_r      <= tlen_nxt;
      bad_r       <= bad_nxt;
      lfail_r     <= lfail_nxt;
      oct_r       <= oct_nxt;
      wr_r        <= wr_r + icp_pkg::QPW'(push_n);
      rd_r        <= rd_r + icp_pkg::QPW'(pop);
      cnt_r       <= cnt_r + icp_pkg::QCW'(push_n) - icp_pkg::QCW'(pop);
    end
  end

  // Input payload and result queue storage.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_req_r  <= in_req_type;
      stg_char_r <= in_char_byte;
    end
    if (push_n != 2'd0) q_r[wr_r] <= res0;
    if (push_n == 2'd2) q_r[wr_r + icp_pkg::QPW'(1)] <= res1;
  end

  // Checks on queue occupancy and list state.
  `ICP_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= icp_pkg::QCW'(icp_pkg::QDEPTH))
  `ICP_ASSERT_NEXT(a_end_clears, clk, rst_n, proc && stg_req_r, !lfail_r && tlen_r == '0)
  `ICP_ASSERT_SAME(a_failed_silent, clk, rst_n, proc && !stg_req_r && lfail_r, push_n == 2'd0)

endmodule

FILE: sim/ipv4_cidr_list_parser_top_test.sv
// ----------------------------------------------------------------------------
// IPv4 CIDR list parser testbench
// Streams character lists into the parser one byte per transfer with random
// idle cycles and result stalls. Every accepted byte is run through a local
// parser model, and each result transfer is checked against the oldest
// predicted result on every field.
// ----------------------------------------------------------------------------
module ipv4_cidr_list_parser_top_test;
  import icp_pkg::*;

  localparam int TOKEN_LIMIT = 18;
  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE_CYCLES = 20;

  // One character or end marker waiting to be sent.
  typedef struct packed {
    logic       req;
    logic [7:0] ch;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_CHAR;
  logic [7:0]  in_char_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_address;
  logic [5:0]  out_prefix_len;
  logic [2:0]  out_status;
  logic        out_last;

  char_item_t char_feed[$];
  char_item_t next_char;
  result_t    awaited_results[$];
  result_t    step_results[$];
  int         chars_sent = 0;
  int         total_chars = 0;
  int         mismatch_count = 0;
  logic       steady;

  // Parser model state.
  logic [7:0] octets[4] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [1:0] part_idx = 2'd0;
  logic [1:0] digit_cnt = 2'd0;
  phase_t     tok_phase = PH_ADDR;
  logic [5:0] prefix_val = 6'd0;
  logic [5:0] tok_len = 6'd0;
  bit         tok_bad = 1'b0;
  bit         list_bad = 1'b0;

  ipv4_cidr_list_parser_top #(
    .MAX_TOKEN_LEN(TOKEN_LIMIT)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_char_byte  (in_char_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_address   (out_address),
    .out_prefix_len(out_prefix_len),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always #10 clk = ~clk;

  // Neither side idles during this stretch of the stream.
  assign steady = (chars_sent >= 600) && (chars_sent < 1000);

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic emit(logic [31:0] addr, logic [5:0] plen, logic [2:0] st);
    result_t r;
    r.address = addr;
    r.prefix_len = plen;
    r.status = st;
    r.last = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic wipe_token();
    octets = '{8'd0, 8'd0, 8'd0, 8'd0};
    part_idx = 2'd0;
    digit_cnt = 2'd0;
    tok_phase = PH_ADDR;
    prefix_val = 6'd0;
    tok_len = 6'd0;
    tok_bad = 1'b0;
  endtask

  // Report the pending token, if there is one, and start a fresh one.
  task automatic close_token();
    bit good;
    if (tok_len == 0) return;
    good = !tok_bad;
    if (tok_phase == PH_ADDR) good = good && (digit_cnt != 0) && (part_idx == 2'd3);
    else if (tok_phase == PH_PREFIX) good = good && (digit_cnt != 0);
    if (good) begin
      emit({octets[0], octets[1], octets[2], octets[3]},
           (tok_phase == PH_ADDR) ? PREFIX_DEF : prefix_val, ST_OK);
    end else begin
      emit(32'd0, 6'd0, ST_BAD_TOKEN);
      list_bad = 1'b1;
    end
    wipe_token();
  endtask

  // Advance the token parse by one digit, dot or slash.
  task automatic absorb_char(logic [7:0] c);
    int v;
    if (tok_bad) return;
    case (tok_phase)
      PH_ADDR: begin
        if (is_digit(c)) begin
          v = int'(octets[part_idx]) * 10 + int'(c - CH_ZERO);
          if (digit_cnt >= 2'd3 || v > int'(OCTET_MAX)) tok_bad = 1'b1;
          else begin
            octets[part_idx] = v[7:0];
            digit_cnt++;
          end
        end else if (c == CH_DOT) begin
          if (digit_cnt == 0 || part_idx >= 2'd3) tok_bad = 1'b1;
          else begin
            digit_cnt = 2'd0;
            part_idx++;
          end
        end else begin
          if (digit_cnt == 0 || part_idx != 2'd3) tok_bad = 1'b1;
          else begin
            tok_phase = PH_PREFIX;
            digit_cnt = 2'd0;
            prefix_val = 6'd0;
          end
        end
      end
      PH_PREFIX: begin
        if (is_digit(c)) begin
          v = int'(prefix_val) * 10 + int'(c - CH_ZERO);
          if (digit_cnt >= 2'd2 || v > int'(PREFIX_MAX)) tok_bad = 1'b1;
          else begin
            prefix_val = v[5:0];
            digit_cnt++;
          end
        end else if (digit_cnt == 0) begin
          tok_bad = 1'b1;
        end else begin
          tok_phase = PH_SKIP;
        end
      end
      default: ;
    endcase
  endtask

  // Predict the results of one accepted input transfer.
  task automatic parse_transfer(logic req, logic [7:0] c);
    step_results.delete();
    if (req == REQ_END) begin
      if (!list_bad) close_token();
      emit(32'd0, 6'd0, list_bad ? ST_REJECTED : ST_ACCEPTED);
      wipe_token();
      list_bad = 1'b0;
    end else if (list_bad) begin
      // Everything up to the end marker is dropped after an error.
    end else if (is_digit(c) || c == CH_DOT || c == CH_SLASH) begin
      if (tok_len >= TOKEN_LIMIT) begin
        emit(32'd0, 6'd0, ST_BAD_TOKEN);
        list_bad = 1'b1;
        wipe_token();
      end else begin
        tok_len++;
        absorb_char(c);
      end
    end else if (c == CH_SPACE || c == CH_NL || c == CH_COMMA) begin
      close_token();
    end else begin
      emit(32'd0, 6'd0, ST_BAD_CHAR);
      list_bad = 1'b1;
      wipe_token();
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic push_char(logic req, logic [7:0] c);
    char_item_t it;
    it.req = req;
    it.ch = c;
    char_feed.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(REQ_CHAR, s[i]);
  endtask

  function automatic string octet_text(int v);
    if ($urandom_range(9) == 0) return $sformatf("%03d", v);
    return $sformatf("%0d", v);
  endfunction

  function automatic string dotted(int n);
    string s;
    s = octet_text($urandom_range(255));
    for (int i = 1; i < n; i++) s = {s, ".", octet_text($urandom_range(255))};
    return s;
  endfunction

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_NL;
      default: return CH_COMMA;
    endcase
  endfunction

  // A byte that is neither a token character nor a delimiter.
  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (is_digit(c) || c == CH_DOT || c == CH_SLASH ||
           c == CH_SPACE || c == CH_NL || c == CH_COMMA);
    return c;
  endfunction

  // One token: mostly well formed, the rest malformed, too long or random.
  function automatic string make_token();
    string s;
    string charset;
    int kind;
    int k;
    charset = "0123456789./";
    kind = $urandom_range(99);
    if (kind < 70) begin
      s = dotted(4);
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(32);
        s = {s, "/", ($urandom_range(7) == 0) ? $sformatf("%02d", k) : $sformatf("%0d", k)};
        if ($urandom_range(9) == 0)
          s = {s, ($urandom_range(1) != 0) ? "." : "/", $sformatf("%0d", $urandom_range(99))};
      end
    end else if (kind < 90) begin
      case ($urandom_range(10))
        0: s = {dotted(3), ".", $sformatf("%0d", $urandom_range(256, 999))};
        1: s = {dotted(3), ".", $sformatf("%04d", $urandom_range(255))};
        2: s = dotted(3);
        3: s = dotted(5);
        4: s = {".", dotted(4)};
        5: s = {dotted(2), "..", dotted(2)};
        6: s = {dotted(4), "/", $sformatf("%0d", $urandom_range(33, 99))};
        7: s = {dotted(4), "/", $sformatf("%03d", $urandom_range(32))};
        8: s = {dotted(4), "/"};
        9: s = {dotted(2), "/", dotted(2)};
        default: s = {dotted(4), "."};
      endcase
    end else if (kind < 95) begin
      // Long tokens: at the limit, then zero to three characters beyond it.
      if ($urandom_range(1) != 0) s = "000.000.000.000/32";
      else s = "111111111111111111";
      repeat ($urandom_range(3)) begin
        k = $urandom_range(11);
        s = {s, charset.substr(k, k)};
      end
    end else begin
      s = "";
      repeat ($urandom_range(1, 6)) begin
        k = $urandom_range(11);
        s = {s, charset.substr(k, k)};
      end
    end
    return s;
  endfunction

  // One list of tokens or a burst of raw bytes, closed by an end marker.
  task automatic make_list();
    int ntok;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 8)) push_char(REQ_CHAR, 8'($urandom_range(255)));
    end else begin
      ntok = $urandom_range(1, 6);
      if ($urandom_range(9) == 0) push_char(REQ_CHAR, pick_delim());
      for (int t = 0; t < ntok; t++) begin
        push_text(make_token());
        if ($urandom_range(24) == 0) push_char(REQ_CHAR, pick_bad_char());
        if (t < ntok - 1 || $urandom_range(1) != 0) begin
          repeat ($urandom_range(1, 2)) push_char(REQ_CHAR, pick_delim());
        end
      end
    end
    push_char(REQ_END, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers one queued item at a time and holds it while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_transfer(in_req_type, in_char_byte);
        chars_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (char_feed.size() > 0 && (steady || $urandom_range(99) >= 35)) begin
          next_char = char_feed.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_char.req;
          in_char_byte <= next_char.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result transfer and drives random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.address = out_address;
        got.prefix_len = out_prefix_len;
        got.status = out_status;
        got.last = out_last;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: addr=%h plen=%0d status=%0d last=%0b",
                     got.address, got.prefix_len, got.status, got.last);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected addr=%h plen=%0d status=%0d last=%0b, %s",
                       want.address, want.prefix_len, want.status, want.last,
                       $sformatf("got addr=%h plen=%0d status=%0d last=%0b",
                                 got.address, got.prefix_len, got.status, got.last));
          end
        end
      end
      out_stall <= steady ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    // Zero address with prefix zero, then an empty token between delimiters.
    push_text("0.0.0.0/0, ");
    push_char(REQ_END, 8'h00);
    // Largest address without a slash, flushed by the end marker.
    push_text("255.255.255.255");
    push_char(REQ_END, 8'hFF);
    // Invalid character, and a malformed token ended by a newline.
    push_char(REQ_CHAR, 8'hFF);
    push_char(REQ_END, 8'h5A);
    push_text("1.\n");
    push_char(REQ_END, 8'hA5);
    while (char_feed.size() < RANDOM_ITEMS + 34) make_list();
    total_chars = char_feed.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_sent < total_chars || awaited_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost result.
  initial begin
    #(4_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/icp_pkg.sv
design/ipv4_cidr_list_parser_top.sv
sim/ipv4_cidr_list_parser_top_test.sv
